[hdl/rgbe_pkg.sv]
`default_nettype none
package rgbe_pkg;

    typedef enum logic [1:0] {
        MODE_HEADER,
        MODE_RLE,
        MODE_RAW,
        MODE_DONE
    } mode_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_FILL,
        SEQ_EMIT
    } seq_t;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_CORRUPT = 2'd1;
    localparam logic [1:0] STATUS_LEGACY  = 2'd2;
    localparam logic [1:0] STATUS_BUSY    = 2'd3;

    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [12:0] WIDTH_RESET  = 13'd1024;
    localparam logic [15:0] HEIGHT_RESET = 16'd512;

    localparam int          MIN_RLE_WIDTH = 8;
    localparam logic [7:0]  RLE_MARK      = 8'h02;
    localparam logic [7:0]  LEGACY_MARK   = 8'h01;
    localparam logic [7:0]  RUN_THRESHOLD = 8'd128;

    typedef struct packed {
        logic       is_tick;
        logic [7:0] data;
    } item_t;

    // Exact single-precision pattern of m * 2^(e-136); zero when m or e is zero.
    function automatic logic [31:0] rgbe_float(input logic [7:0] m, input logic [7:0] e);
        logic [2:0]  p;
        logic [8:0]  pe;
        logic [31:0] wide;
        logic [31:0] res;
        p = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (m[i]) begin
                p = 3'(i);
            end
        end
        pe = 9'(p) + 9'(e);
        wide = 32'(m);
        if (m == 8'd0 || e == 8'd0) begin
            res = 32'd0;
        end else if (pe >= 9'd10) begin
            res = {1'b0, 8'(pe - 9'd9), 23'(wide << (5'd23 - 5'(p)))};
        end else begin
            res = wide << (6'(e) + 6'd13);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[hdl/rgbe_scanline_rle_decoder.sv]
`default_nettype none
// Radiance RGBE pixel-data decoder. Feed the file's pixel bytes after the text
// header on the s_ stream (tuser low), with image_width and image_height set
// through the write port beforehand; tuser high is a tick that releases one
// pending pixel of an exponent-channel run. Each result word on m_ is either a
// pixel (tuser low) carrying IEEE single patterns per channel, or a status
// (tuser high); tlast marks the last pixel of a scanline. A raw byte, a status
// and a literal byte pass through the queue and the sequencer; a pixel also
// passes the EMIT state for the line-store read and conversion. An R, G or
// B run of n bytes holds the sequencer for n store writes, one per cycle. A
// four-word input queue lets the upstream keep streaming meanwhile.
module rgbe_scanline_rle_decoder #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic         cfg_index,
    input  wire logic [15:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // byte_value
    input  wire logic         s_tuser,   // cmd
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,   // red_bits, green_bits, blue_bits, pixel_column,
                                         // pixel_row, image_end, status, zero pad
    output logic              m_tuser,   // kind
    output logic              m_tlast    // row_end
);

    logic [12:0]     width_reg, width_next;
    logic [15:0]     height_reg, height_next;
    logic            q_valid, q_ready;
    rgbe_pkg::item_t q_item;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                rgbe_pkg::REG_IMAGE_WIDTH:  width_next  = cfg_wdata[12:0];
                rgbe_pkg::REG_IMAGE_HEIGHT: height_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= rgbe_pkg::WIDTH_RESET;
            height_reg <= rgbe_pkg::HEIGHT_RESET;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    rgbe_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_cmd   (s_tuser),
        .in_byte  (s_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    rgbe_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .image_width  (width_reg),
        .image_height (height_reg),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

    // a status word carries nothing but its code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == rgbe_pkg::KIND_STATUS |-> m_tdata[124:0] == 125'd0 && !m_tlast)
        else $error("status word with nonzero payload");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == rgbe_pkg::KIND_PIXEL |-> m_tdata[126:125] == rgbe_pkg::STATUS_OK)
        else $error("pixel word with nonzero status");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == rgbe_pkg::KIND_PIXEL && m_tdata[124] |-> m_tlast)
        else $error("image end without row end");

endmodule
`default_nettype wire

[hdl/rgbe_front.sv]
`default_nettype none
module rgbe_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             in_cmd,
    input  wire logic [7:0]       in_byte,
    output logic                  q_valid,
    input  wire logic             q_ready,
    output rgbe_pkg::item_t       q_item
);

    localparam int DEPTH = 4;

    rgbe_pkg::item_t  fifo_mem [DEPTH];
    logic [1:0]       wr_ptr_reg, wr_ptr_next;
    logic [1:0]       rd_ptr_reg, rd_ptr_next;
    logic [2:0]       count_reg, count_next;
    logic             push, pop;
    rgbe_pkg::item_t  in_item;

    always_comb begin
        in_item.is_tick = (in_cmd == rgbe_pkg::CMD_TICK);
        in_item.data    = in_item.is_tick ? 8'd0 : in_byte;
    end

    assign in_ready = (count_reg != 3'(DEPTH));
    assign q_valid  = (count_reg != 3'd0);
    assign q_item   = fifo_mem[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        count_next  = count_reg + 3'(push) - 3'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

[hdl/rgbe_back.sv]
`default_nettype none
module rgbe_back #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [12:0]      image_width,
    input  wire logic [15:0]      image_height,
    input  wire logic             q_valid,
    output logic                  q_ready,
    input  wire rgbe_pkg::item_t  q_item,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [127:0]          m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic [7:0] red_mem   [MAX_WIDTH];
    logic [7:0] green_mem [MAX_WIDTH];
    logic [7:0] blue_mem  [MAX_WIDTH];

    rgbe_pkg::seq_t  seq_reg, seq_next;
    rgbe_pkg::mode_t mode_reg, mode_next;
    logic [23:0] hdr_reg, hdr_next;
    logic [1:0]  slot_reg, slot_next;
    logic [1:0]  chan_reg, chan_next;
    logic [12:0] pos_reg, pos_next;
    logic [7:0]  lit_reg, lit_next;
    logic        await_reg, await_next;
    logic [7:0]  pend_reg, pend_next;
    logic [7:0]  pexp_reg, pexp_next;
    logic [15:0] row_reg, row_next;
    logic [1:0]  sticky_reg, sticky_next;
    logic [7:0]  fill_left_reg, fill_left_next;
    logic [7:0]  fill_byte_reg, fill_byte_next;
    logic [12:0] em_col_reg, em_col_next;
    logic [7:0]  em_exp_reg, em_exp_next;
    logic [23:0] em_rgb_reg, em_rgb_next;
    logic        em_mem_reg, em_mem_next;
    logic [23:0] rd_rgb_reg;

    logic        ov_reg, ov_next;
    logic        o_kind_reg, o_kind_next;
    logic [31:0] o_red_reg, o_red_next;
    logic [31:0] o_green_reg, o_green_next;
    logic [31:0] o_blue_reg, o_blue_next;
    logic [11:0] o_col_reg, o_col_next;
    logic [15:0] o_row_reg, o_row_next;
    logic        o_rend_reg, o_rend_next;
    logic        o_iend_reg, o_iend_next;
    logic [1:0]  o_status_reg, o_status_next;

    logic        mem_we;
    logic [1:0]  mem_lane;
    logic [7:0]  mem_wdata;
    logic        rd_en;
    logic        out_free;
    logic [12:0] eff_w;
    logic [15:0] eff_h;
    logic [7:0]  b;
    logic [6:0]  run_n;
    logic [23:0] px_rgb;
    logic        rend, iend;

    always_comb begin
        eff_w = image_width;
        if (image_width == 13'd0) begin
            eff_w = 13'd1;
        end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
            eff_w = 13'(MAX_WIDTH);
        end
        eff_h = (image_height == 16'd0) ? 16'd1 : image_height;
    end

    assign out_free = !ov_reg || m_tready;
    assign b        = q_item.data;
    assign run_n    = b[6:0];
    assign rd_en    = (seq_reg == rgbe_pkg::SEQ_IDLE) && (32'(pos_reg) < 32'(MAX_WIDTH));
    assign px_rgb   = em_mem_reg ? rd_rgb_reg : em_rgb_reg;
    assign rend     = (14'(em_col_reg) + 14'd1) >= 14'(eff_w);
    assign iend     = rend && ((17'(row_reg) + 17'd1) >= 17'(eff_h));

    always_comb begin
        seq_next       = seq_reg;
        mode_next      = mode_reg;
        hdr_next       = hdr_reg;
        slot_next      = slot_reg;
        chan_next      = chan_reg;
        pos_next       = pos_reg;
        lit_next       = lit_reg;
        await_next     = await_reg;
        pend_next      = pend_reg;
        pexp_next      = pexp_reg;
        row_next       = row_reg;
        sticky_next    = sticky_reg;
        fill_left_next = fill_left_reg;
        fill_byte_next = fill_byte_reg;
        em_col_next    = em_col_reg;
        em_exp_next    = em_exp_reg;
        em_rgb_next    = em_rgb_reg;
        em_mem_next    = em_mem_reg;
        ov_next        = ov_reg && !m_tready;
        o_kind_next    = o_kind_reg;
        o_red_next     = o_red_reg;
        o_green_next   = o_green_reg;
        o_blue_next    = o_blue_reg;
        o_col_next     = o_col_reg;
        o_row_next     = o_row_reg;
        o_rend_next    = o_rend_reg;
        o_iend_next    = o_iend_reg;
        o_status_next  = o_status_reg;
        q_ready        = 1'b0;
        mem_we         = 1'b0;
        mem_lane       = chan_reg;
        mem_wdata      = b;

        case (seq_reg)
            rgbe_pkg::SEQ_IDLE: begin
                if (q_valid && out_free) begin
                    q_ready = 1'b1;
                    // status word: everything but kind and code is zero
                    o_kind_next   = rgbe_pkg::KIND_STATUS;
                    o_red_next    = 32'd0;
                    o_green_next  = 32'd0;
                    o_blue_next   = 32'd0;
                    o_col_next    = 12'd0;
                    o_row_next    = 16'd0;
                    o_rend_next   = 1'b0;
                    o_iend_next   = 1'b0;
                    o_status_next = sticky_reg;
                    if (sticky_reg != rgbe_pkg::STATUS_OK) begin
                        ov_next = 1'b1;
                    end else if (q_item.is_tick) begin
                        if (mode_reg == rgbe_pkg::MODE_RLE && pend_reg != 8'd0) begin
                            pend_next   = pend_reg - 8'd1;
                            em_col_next = pos_reg;
                            pos_next    = pos_reg + 13'd1;
                            em_exp_next = pexp_reg;
                            em_mem_next = 1'b1;
                            seq_next    = rgbe_pkg::SEQ_EMIT;
                        end
                    end else if (mode_reg == rgbe_pkg::MODE_DONE) begin
                        // image finished: drop
                    end else if (pend_reg != 8'd0) begin
                        o_status_next = rgbe_pkg::STATUS_BUSY;
                        ov_next       = 1'b1;
                    end else if (mode_reg == rgbe_pkg::MODE_RLE) begin
                        if (await_reg) begin
                            await_next = 1'b0;
                            lit_next   = 8'd0;
                            if (chan_reg != 2'd3) begin
                                fill_left_next = lit_reg;
                                fill_byte_next = b;
                                seq_next       = rgbe_pkg::SEQ_FILL;
                            end else begin
                                em_col_next = pos_reg;
                                pos_next    = pos_reg + 13'd1;
                                pend_next   = lit_reg - 8'd1;
                                pexp_next   = b;
                                em_exp_next = b;
                                em_mem_next = 1'b1;
                                seq_next    = rgbe_pkg::SEQ_EMIT;
                            end
                        end else if (lit_reg != 8'd0) begin
                            lit_next = lit_reg - 8'd1;
                            if (chan_reg != 2'd3) begin
                                mem_we   = 1'b1;
                                pos_next = pos_reg + 13'd1;
                                if (lit_reg == 8'd1 &&
                                    (14'(pos_reg) + 14'd1) >= 14'(eff_w)) begin
                                    pos_next  = 13'd0;
                                    chan_next = chan_reg + 2'd1;
                                end
                            end else begin
                                em_col_next = pos_reg;
                                pos_next    = pos_reg + 13'd1;
                                em_exp_next = b;
                                em_mem_next = 1'b1;
                                seq_next    = rgbe_pkg::SEQ_EMIT;
                            end
                        end else if (b > rgbe_pkg::RUN_THRESHOLD) begin
                            if ((14'(pos_reg) + 14'(run_n)) > 14'(eff_w)) begin
                                sticky_next   = rgbe_pkg::STATUS_CORRUPT;
                                o_status_next = rgbe_pkg::STATUS_CORRUPT;
                                ov_next       = 1'b1;
                            end else begin
                                lit_next   = 8'(run_n);
                                await_next = 1'b1;
                            end
                        end else if (b == 8'd0 ||
                                     (14'(pos_reg) + 14'(b)) > 14'(eff_w)) begin
                            sticky_next   = rgbe_pkg::STATUS_CORRUPT;
                            o_status_next = rgbe_pkg::STATUS_CORRUPT;
                            ov_next       = 1'b1;
                        end else begin
                            lit_next = b;
                        end
                    end else if (slot_reg != 2'd3) begin
                        hdr_next  = {hdr_reg[15:0], b};
                        slot_next = slot_reg + 2'd1;
                    end else begin
                        slot_next = 2'd0;
                        hdr_next  = 24'd0;
                        if (mode_reg == rgbe_pkg::MODE_HEADER &&
                            hdr_reg[23:16] == rgbe_pkg::RLE_MARK &&
                            hdr_reg[15:8] == rgbe_pkg::RLE_MARK &&
                            !hdr_reg[7] &&
                            {hdr_reg[7:0], b} == 16'(eff_w) &&
                            32'(eff_w) >= 32'(rgbe_pkg::MIN_RLE_WIDTH)) begin
                            mode_next = rgbe_pkg::MODE_RLE;
                            chan_next = 2'd0;
                            pos_next  = 13'd0;
                        end else if (mode_reg == rgbe_pkg::MODE_HEADER &&
                                     hdr_reg[23:16] == rgbe_pkg::LEGACY_MARK &&
                                     hdr_reg[15:8] == rgbe_pkg::LEGACY_MARK &&
                                     hdr_reg[7:0] == rgbe_pkg::LEGACY_MARK) begin
                            sticky_next   = rgbe_pkg::STATUS_LEGACY;
                            o_status_next = rgbe_pkg::STATUS_LEGACY;
                            ov_next       = 1'b1;
                        end else begin
                            if (mode_reg == rgbe_pkg::MODE_HEADER) begin
                                mode_next   = rgbe_pkg::MODE_RAW;
                                em_col_next = 13'd0;
                                pos_next    = 13'd1;
                            end else begin
                                em_col_next = pos_reg;
                                pos_next    = pos_reg + 13'd1;
                            end
                            em_rgb_next = hdr_reg;
                            em_exp_next = b;
                            em_mem_next = 1'b0;
                            seq_next    = rgbe_pkg::SEQ_EMIT;
                        end
                    end
                end
            end
            rgbe_pkg::SEQ_FILL: begin
                // one store entry per cycle for a run
                mem_we         = 1'b1;
                mem_wdata      = fill_byte_reg;
                pos_next       = pos_reg + 13'd1;
                fill_left_next = fill_left_reg - 8'd1;
                if (fill_left_reg <= 8'd1) begin
                    seq_next = rgbe_pkg::SEQ_IDLE;
                    if ((14'(pos_reg) + 14'd1) >= 14'(eff_w)) begin
                        pos_next  = 13'd0;
                        chan_next = chan_reg + 2'd1;
                    end
                end
            end
            rgbe_pkg::SEQ_EMIT: begin
                if (out_free) begin
                    ov_next       = 1'b1;
                    o_kind_next   = rgbe_pkg::KIND_PIXEL;
                    o_red_next    = rgbe_pkg::rgbe_float(px_rgb[23:16], em_exp_reg);
                    o_green_next  = rgbe_pkg::rgbe_float(px_rgb[15:8], em_exp_reg);
                    o_blue_next   = rgbe_pkg::rgbe_float(px_rgb[7:0], em_exp_reg);
                    o_col_next    = em_col_reg[11:0];
                    o_row_next    = row_reg;
                    o_rend_next   = rend;
                    o_iend_next   = iend;
                    o_status_next = rgbe_pkg::STATUS_OK;
                    seq_next      = rgbe_pkg::SEQ_IDLE;
                    if (rend) begin
                        mode_next  = iend ? rgbe_pkg::MODE_DONE : rgbe_pkg::MODE_HEADER;
                        row_next   = iend ? row_reg : row_reg + 16'd1;
                        hdr_next   = 24'd0;
                        slot_next  = 2'd0;
                        chan_next  = 2'd0;
                        pos_next   = 13'd0;
                        lit_next   = 8'd0;
                        await_next = 1'b0;
                        pend_next  = 8'd0;
                    end
                end
            end
            default: begin
                seq_next = rgbe_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we && 32'(pos_reg) < 32'(MAX_WIDTH)) begin
            case (mem_lane)
                2'd0:    red_mem[pos_reg[AW-1:0]]   <= mem_wdata;
                2'd1:    green_mem[pos_reg[AW-1:0]] <= mem_wdata;
                2'd2:    blue_mem[pos_reg[AW-1:0]]  <= mem_wdata;
                default: ;
            endcase
        end
        if (rd_en) begin
            rd_rgb_reg <= {red_mem[pos_reg[AW-1:0]], green_mem[pos_reg[AW-1:0]],
                           blue_mem[pos_reg[AW-1:0]]};
        end
    end

    always_ff @(posedge aclk) begin
        fill_left_reg <= fill_left_next;
        fill_byte_reg <= fill_byte_next;
        em_col_reg    <= em_col_next;
        em_exp_reg    <= em_exp_next;
        em_rgb_reg    <= em_rgb_next;
        em_mem_reg    <= em_mem_next;
        o_kind_reg    <= o_kind_next;
        o_red_reg     <= o_red_next;
        o_green_reg   <= o_green_next;
        o_blue_reg    <= o_blue_next;
        o_col_reg     <= o_col_next;
        o_row_reg     <= o_row_next;
        o_rend_reg    <= o_rend_next;
        o_iend_reg    <= o_iend_next;
        o_status_reg  <= o_status_next;
        if (!aresetn) begin
            seq_reg    <= rgbe_pkg::SEQ_IDLE;
            mode_reg   <= rgbe_pkg::MODE_HEADER;
            hdr_reg    <= 24'd0;
            slot_reg   <= 2'd0;
            chan_reg   <= 2'd0;
            pos_reg    <= 13'd0;
            lit_reg    <= 8'd0;
            await_reg  <= 1'b0;
            pend_reg   <= 8'd0;
            pexp_reg   <= 8'd0;
            row_reg    <= 16'd0;
            sticky_reg <= rgbe_pkg::STATUS_OK;
            ov_reg     <= 1'b0;
        end else begin
            seq_reg    <= seq_next;
            mode_reg   <= mode_next;
            hdr_reg    <= hdr_next;
            slot_reg   <= slot_next;
            chan_reg   <= chan_next;
            pos_reg    <= pos_next;
            lit_reg    <= lit_next;
            await_reg  <= await_next;
            pend_reg   <= pend_next;
            pexp_reg   <= pexp_next;
            row_reg    <= row_next;
            sticky_reg <= sticky_next;
            ov_reg     <= ov_next;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_rend_reg;
    assign m_tdata  = {1'b0, o_status_reg, o_iend_reg, o_row_reg, o_col_reg,
                       o_blue_reg, o_green_reg, o_red_reg};

endmodule
`default_nettype wire

[tb/rgbe_decoder_checker.sv]
`timescale 1ns / 100ps
`default_nettype none
module rgbe_decoder_checker
    import rgbe_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic         cfg_index,
    input  wire logic [15:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [7:0]   s_tdata,
    input  wire logic         s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [127:0] m_tdata,
    input  wire logic         m_tuser,
    input  wire logic         m_tlast,
    output int                mismatches,
    output int                outstanding
);

    typedef struct packed {
        logic        kind;
        logic [31:0] red;
        logic [31:0] green;
        logic [31:0] blue;
        logic [11:0] col;
        logic [15:0] row;
        logic        row_end;
        logic        image_end;
        logic [1:0]  status;
    } pixel_word_t;

    logic [23:0] line_rgb [0:4095];
    mode_t       mode;
    logic [31:0] hdr_shift;
    int          hdr_slot;
    int          chan;
    int          pos;
    int          lit_left;
    logic        run_value_next;
    int          run_pending;
    logic [7:0]  run_exp;
    logic [15:0] row_num;
    logic [1:0]  sticky;
    logic [12:0] width_reg;
    logic [15:0] height_reg;

    pixel_word_t expected_words [$];

    function automatic int eff_width();
        if (width_reg == 13'd0) return 1;
        if (width_reg > 13'd4096) return 4096;
        return int'(width_reg);
    endfunction

    function automatic int eff_height();
        return height_reg == 16'd0 ? 1 : int'(height_reg);
    endfunction

    // m * 2^(e-136) as a single-precision pattern
    function automatic logic [31:0] to_single(input logic [7:0] m, input logic [7:0] e);
        int          p;
        int          ei;
        logic [31:0] t;
        if (m == 8'd0 || e == 8'd0) return 32'd0;
        ei = int'(e);
        p = 7;
        while (!m[p]) p--;
        if (p + ei >= 10) begin
            t = 32'(m) << (23 - p);
            return {1'b0, 8'(p + ei - 9), t[22:0]};
        end
        return 32'(m) << (ei + 13);
    endfunction

    task automatic new_row();
        mode = MODE_HEADER;
        hdr_shift = '0;
        hdr_slot = 0;
        chan = 0;
        pos = 0;
        lit_left = 0;
        run_value_next = 1'b0;
        run_pending = 0;
    endtask

    task automatic status_word(input logic [1:0] code, output pixel_word_t w);
        w = '0;
        w.kind = KIND_STATUS;
        w.status = code;
    endtask

    task automatic raise(input logic [1:0] code, output pixel_word_t w);
        sticky = code;
        status_word(code, w);
    endtask

    task automatic emit_pixel(input logic [23:0] rgb, input logic [7:0] e, input int col,
                              output pixel_word_t w);
        logic rend;
        logic iend;
        rend = col + 1 >= eff_width();
        iend = rend && (int'(row_num) + 1 >= eff_height());
        w.kind = KIND_PIXEL;
        w.red = to_single(rgb[23:16], e);
        w.green = to_single(rgb[15:8], e);
        w.blue = to_single(rgb[7:0], e);
        w.col = 12'(col);
        w.row = row_num;
        w.row_end = rend;
        w.image_end = iend;
        w.status = STATUS_OK;
        if (rend) begin
            new_row();
            if (iend) mode = MODE_DONE;
            else row_num = row_num + 16'd1;
        end
    endtask

    task automatic put_channel(input int idx, input int c, input logic [7:0] b);
        if (idx < 4096 && c < 3) line_rgb[idx][16 - 8 * c +: 8] = b;
    endtask

    task automatic rle_byte(input logic [7:0] b, output logic got, output pixel_word_t w);
        int wd;
        int c;
        int n;
        int col;
        wd = eff_width();
        c = chan;
        got = 1'b0;
        if (run_value_next) begin
            n = lit_left;
            run_value_next = 1'b0;
            lit_left = 0;
            if (c < 3) begin
                for (int k = 0; k < n; k++) put_channel(pos + k, c, b);
                pos += n;
                if (pos >= wd) begin
                    pos = 0;
                    chan = c + 1;
                end
                return;
            end
            col = pos++;
            run_pending = n - 1;
            run_exp = b;
            emit_pixel(line_rgb[col], b, col, w);
            got = 1'b1;
        end else if (lit_left > 0) begin
            lit_left--;
            if (c < 3) begin
                put_channel(pos, c, b);
                pos++;
                if (lit_left == 0 && pos >= wd) begin
                    pos = 0;
                    chan = c + 1;
                end
                return;
            end
            col = pos++;
            emit_pixel(line_rgb[col], b, col, w);
            got = 1'b1;
        end else if (b > RUN_THRESHOLD) begin
            n = int'(b[6:0]);
            if (pos + n > wd) begin
                raise(STATUS_CORRUPT, w);
                got = 1'b1;
                return;
            end
            lit_left = n;
            run_value_next = 1'b1;
        end else if (b == 8'd0 || pos + int'(b) > wd) begin
            raise(STATUS_CORRUPT, w);
            got = 1'b1;
        end else begin
            lit_left = int'(b);
        end
    endtask

    task automatic quad_byte(input logic [7:0] b, output logic got, output pixel_word_t w);
        logic [31:0] q;
        int          col;
        got = 1'b0;
        hdr_shift = {hdr_shift[23:0], b};
        if (hdr_slot < 3) begin
            hdr_slot++;
            return;
        end
        hdr_slot = 0;
        q = hdr_shift;
        hdr_shift = '0;
        got = 1'b1;
        if (mode == MODE_HEADER) begin
            if (q[31:24] == RLE_MARK && q[23:16] == RLE_MARK && !q[15]
                    && int'(q[15:0]) == eff_width() && eff_width() >= MIN_RLE_WIDTH) begin
                mode = MODE_RLE;
                chan = 0;
                pos = 0;
                got = 1'b0;
                return;
            end
            if (q[31:24] == LEGACY_MARK && q[23:16] == LEGACY_MARK
                    && q[15:8] == LEGACY_MARK) begin
                raise(STATUS_LEGACY, w);
                return;
            end
            mode = MODE_RAW;
            pos = 1;
            emit_pixel(q[31:8], q[7:0], 0, w);
            return;
        end
        col = pos++;
        emit_pixel(q[31:8], q[7:0], col, w);
    endtask

    task automatic decode_word(input logic is_tick, input logic [7:0] b,
                               output logic got, output pixel_word_t w);
        int col;
        got = 1'b0;
        w = '0;
        if (sticky != STATUS_OK) begin
            status_word(sticky, w);
            got = 1'b1;
        end else if (is_tick == CMD_TICK) begin
            if (mode == MODE_RLE && run_pending > 0) begin
                run_pending--;
                col = pos++;
                emit_pixel(line_rgb[col], run_exp, col, w);
                got = 1'b1;
            end
        end else if (mode == MODE_DONE) begin
            got = 1'b0;
        end else if (run_pending > 0) begin
            status_word(STATUS_BUSY, w);
            got = 1'b1;
        end else if (mode == MODE_RLE) begin
            rle_byte(b, got, w);
        end else begin
            quad_byte(b, got, w);
        end
    endtask

    always @(posedge aclk) begin
        logic        got;
        pixel_word_t w;
        pixel_word_t act;
        pixel_word_t exp_w;
        if (!aresetn) begin
            new_row();
            run_exp = '0;
            row_num = '0;
            sticky = STATUS_OK;
            width_reg = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            expected_words.delete();
            mismatches <= 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_IMAGE_WIDTH) width_reg = cfg_wdata[12:0];
                else height_reg = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                decode_word(s_tuser, s_tdata, got, w);
                if (got) expected_words.push_back(w);
            end
            if (m_tvalid && m_tready) begin
                act.kind = m_tuser;
                act.red = m_tdata[31:0];
                act.green = m_tdata[63:32];
                act.blue = m_tdata[95:64];
                act.col = m_tdata[107:96];
                act.row = m_tdata[123:108];
                act.row_end = m_tlast;
                act.image_end = m_tdata[124];
                act.status = m_tdata[126:125];
                if (expected_words.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result word kind=%0d status=%0d",
                                 $realtime, act.kind, act.status);
                    mismatches <= mismatches + 1;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (act !== exp_w) begin
                        if (mismatches < 10) begin
                            $display("%0t: mismatch", $realtime);
                            $display("  exp kind=%0d r=%h g=%h b=%h col=%0d row=%0d last=%0d end=%0d st=%0d",
                                     exp_w.kind, exp_w.red, exp_w.green, exp_w.blue, exp_w.col,
                                     exp_w.row, exp_w.row_end, exp_w.image_end, exp_w.status);
                            $display("  got kind=%0d r=%h g=%h b=%h col=%0d row=%0d last=%0d end=%0d st=%0d",
                                     act.kind, act.red, act.green, act.blue, act.col,
                                     act.row, act.row_end, act.image_end, act.status);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
        outstanding <= expected_words.size();
    end

endmodule
`default_nettype wire

[tb/tb_rgbe_scanline_rle_decoder.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_rgbe_scanline_rle_decoder;
    import rgbe_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic         cfg_index;
    logic [15:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;
    int           mismatches;
    int           outstanding;
    int           words_sent;
    int           gap_max;
    int           cur_width;
    int           stall_cycles;

    rgbe_scanline_rle_decoder dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    rgbe_decoder_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= 3000) begin
            $display("rgbe_scanline_rle_decoder test failed");
            $finish;
        end
    end

    // result side: random back-pressure, plus one long hold so the input queue fills
    initial begin
        int n_results;
        int w;
        int rx_max;
        n_results = 0;
        rx_max = 18;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (n_results % 40 == 0) rx_max = ($urandom_range(0, 2) == 0) ? 0 : 18;
            w = (n_results == 40) ? 500 : $urandom_range(0, rx_max);
            if (w > 0) begin
                m_tready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(negedge aclk); while (!m_tvalid);
            @(posedge aclk);
            n_results++;
        end
    end

    task automatic send_word(input logic is_tick, input logic [7:0] b);
        int g;
        g = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= is_tick;
        s_tdata <= b;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        words_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        // an occasional tick with nothing pending must be ignored
        if ($urandom_range(0, 15) == 0) send_word(CMD_TICK, 8'($urandom));
        send_word(CMD_BYTE, b);
    endtask

    function automatic logic [7:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // hold off until every result is back and the block has gone quiet
    task automatic drain();
        if (s_tvalid) s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (outstanding == 0);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            cur_width = (val[12:0] == 0) ? 1 : (val[12:0] > 4096) ? 4096 : int'(val[12:0]);
    endtask

    task automatic raw_line();
        logic [7:0] q [4];
        for (int i = 0; i < 4; i++) q[i] = pick_value();
        if ($urandom_range(0, 3) == 0) begin
            q[0] = RLE_MARK;
            q[1] = RLE_MARK;
            if (cur_width < MIN_RLE_WIDTH && $urandom_range(0, 1) == 0) begin
                q[2] = 8'h00;
                q[3] = 8'(cur_width);
            end else begin
                q[2] = 8'h80 | 8'($urandom);
            end
        end
        if (q[0] == LEGACY_MARK && q[1] == LEGACY_MARK && q[2] == LEGACY_MARK) q[2] = 8'h00;
        if (q[0] == RLE_MARK && q[1] == RLE_MARK && !q[2][7]
                && {q[2], q[3]} == 16'(cur_width) && cur_width >= MIN_RLE_WIDTH)
            q[3] = q[3] ^ 8'h01;
        for (int i = 0; i < 4; i++) send_byte(q[i]);
        for (int p = 1; p < cur_width; p++)
            for (int i = 0; i < 4; i++) send_byte(pick_value());
    endtask

    task automatic rle_line();
        int left;
        int n;
        int lim;
        send_byte(RLE_MARK);
        send_byte(RLE_MARK);
        send_byte(8'(cur_width >> 8));
        send_byte(8'(cur_width));
        for (int c = 0; c < 4; c++) begin
            left = cur_width;
            while (left > 0) begin
                if (cur_width > 300 || $urandom_range(0, 1) == 0) begin
                    lim = (left < 127) ? left : 127;
                    n = (cur_width > 300) ? lim : $urandom_range(1, lim);
                    send_byte(RUN_THRESHOLD + 8'(n));
                    send_byte(pick_value());
                    if (c == 3) begin
                        for (int k = 1; k < n; k++) begin
                            // a byte while run pixels are pending is refused
                            if ($urandom_range(0, 19) == 0) send_word(CMD_BYTE, 8'($urandom));
                            send_word(CMD_TICK, 8'($urandom));
                        end
                    end
                end else begin
                    lim = (left < 128) ? left : 128;
                    n = $urandom_range(1, lim);
                    send_byte(8'(n));
                    for (int k = 0; k < n; k++) send_byte(pick_value());
                end
                left -= n;
            end
        end
    endtask

    task automatic any_line();
        gap_max = ($urandom_range(0, 2) == 0) ? 0 : 18;
        if (cur_width >= MIN_RLE_WIDTH && $urandom_range(0, 3) != 0) rle_line();
        else raw_line();
    endtask

    initial begin
        int w;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tuser = CMD_BYTE;
        s_tdata = '0;
        words_sent = 0;
        gap_max = 18;
        cur_width = int'(WIDTH_RESET);
        stall_cycles = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
        write_reg(REG_IMAGE_WIDTH, 16'd0);
        raw_line();
        raw_line();
        write_reg(REG_IMAGE_WIDTH, 16'd7);
        raw_line();
        write_reg(REG_IMAGE_WIDTH, 16'd8);
        rle_line();
        raw_line();
        drain();

        while (words_sent < 560) begin
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 6))
                    0: w = $urandom_range(1, 7);
                    1: w = $urandom_range(30, 60);
                    default: w = $urandom_range(8, 24);
                endcase
                write_reg(REG_IMAGE_WIDTH, 16'(w));
            end
            any_line();
            if ($urandom_range(0, 4) == 0) drain();
        end

        // error codes and image completion are permanent, so only one closes the run
        case ($urandom_range(0, 2))
            0: begin
                write_reg(REG_IMAGE_HEIGHT, 16'd0);
                any_line();
                repeat (8) send_word(1'($urandom), 8'($urandom));
            end
            1: begin
                // an oversized width clamps to the line store size
                write_reg(REG_IMAGE_WIDTH, ($urandom_range(0, 1) == 0) ? 16'h1FFF
                                                                      : 16'($urandom_range(8, 100)));
                send_byte(RLE_MARK);
                send_byte(RLE_MARK);
                send_byte(8'(cur_width >> 8));
                send_byte(8'(cur_width));
                send_byte((cur_width < 127) ? 8'hFF : 8'h00);
                repeat (8) send_word(1'($urandom), 8'($urandom));
            end
            default: begin
                send_byte(LEGACY_MARK);
                send_byte(LEGACY_MARK);
                send_byte(LEGACY_MARK);
                send_byte(pick_value());
                repeat (8) send_word(1'($urandom), 8'($urandom));
            end
        endcase

        drain();
        if (mismatches == 0) begin
            $display("rgbe_scanline_rle_decoder test passed");
        end else begin
            $display("rgbe_scanline_rle_decoder test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
